[rtl/cst_pkg.sv]
`timescale 1ns / 1ps
package cst_pkg;

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_IDENT   = 7'b0000010,
      MODE_NUM     = 7'b0000100,
      MODE_CHAR    = 7'b0001000,
      MODE_STR     = 7'b0010000,
      MODE_SYM     = 7'b0100000,
      MODE_COMMENT = 7'b1000000
   } mode_type;

   localparam logic [5:0] KIND_IDENT  = 6'd0;
   localparam logic [5:0] KIND_INT    = 6'd1;
   localparam logic [5:0] KIND_FLOAT  = 6'd2;
   localparam logic [5:0] KIND_CHAR   = 6'd3;
   localparam logic [5:0] KIND_STRING = 6'd4;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_IDENT_LONG = 4'd1;
   localparam logic [3:0] ERR_NUM_LONG   = 4'd2;
   localparam logic [3:0] ERR_TWO_POINT  = 4'd3;
   localparam logic [3:0] ERR_X_POINT    = 4'd4;
   localparam logic [3:0] ERR_X_PLACE    = 4'd5;
   localparam logic [3:0] ERR_FLOAT_LET  = 4'd6;
   localparam logic [3:0] ERR_HEX_LET    = 4'd7;
   localparam logic [3:0] ERR_CHAR       = 4'd8;
   localparam logic [3:0] ERR_STR_LONG   = 4'd9;
   localparam logic [3:0] ERR_BAD_BYTE   = 4'd10;

   localparam int LEN_BITS = 12;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [11:0] length;
      logic [3:0]  error;
      logic        done;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       cnt;
      result_type r0;
      result_type r1;
   } entry_type;

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      case (c)
         8'h2b: single_kind = 6'd5;
         8'h2d: single_kind = 6'd6;
         8'h2a: single_kind = 6'd7;
         8'h2f: single_kind = 6'd8;
         8'h25: single_kind = 6'd9;
         8'h28: single_kind = 6'd10;
         8'h29: single_kind = 6'd11;
         8'h7b: single_kind = 6'd12;
         8'h7d: single_kind = 6'd13;
         8'h5b: single_kind = 6'd14;
         8'h5d: single_kind = 6'd15;
         8'h3e: single_kind = 6'd16;
         8'h3c: single_kind = 6'd17;
         8'h3d: single_kind = 6'd18;
         8'h21: single_kind = 6'd19;
         8'h7c: single_kind = 6'd20;
         8'h26: single_kind = 6'd21;
         8'h7e: single_kind = 6'd22;
         8'h2e: single_kind = 6'd23;
         8'h3b: single_kind = 6'd24;
         default: single_kind = 6'd0;
      endcase
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      logic eq;
      eq = (b == 8'h3d);
      case (a)
         8'h2b: pair_kind = (b == 8'h2b) ? 6'd25 : (eq ? 6'd26 : 6'd0);
         8'h2d: pair_kind = (b == 8'h2d) ? 6'd27 : (eq ? 6'd28 :
                            ((b == 8'h3e) ? 6'd29 : 6'd0));
         8'h2f: pair_kind = eq ? 6'd30 : 6'd0;
         8'h2a: pair_kind = eq ? 6'd31 : 6'd0;
         8'h25: pair_kind = eq ? 6'd32 : 6'd0;
         8'h3e: pair_kind = eq ? 6'd33 : 6'd0;
         8'h3c: pair_kind = eq ? 6'd34 : 6'd0;
         8'h3d: pair_kind = eq ? 6'd35 : 6'd0;
         8'h21: pair_kind = eq ? 6'd36 : 6'd0;
         8'h7e: pair_kind = eq ? 6'd36 : 6'd0;
         8'h7c: pair_kind = (b == 8'h7c) ? 6'd37 : (eq ? 6'd38 : 6'd0);
         8'h26: pair_kind = (b == 8'h26) ? 6'd39 : (eq ? 6'd40 : 6'd0);
         default: pair_kind = 6'd0;
      endcase
   endfunction

   function automatic logic combinable(input logic [7:0] c);
      combinable = (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2f) || (c == 8'h2a) ||
                   (c == 8'h25) || (c == 8'h3e) || (c == 8'h3c) || (c == 8'h3d) ||
                   (c == 8'h21) || (c == 8'h7c) || (c == 8'h26) || (c == 8'h7e);
   endfunction

endpackage

[rtl/c_source_tokenizer.sv]
`timescale 1ns / 1ps
// C subset tokenizer, one source byte per beat.
// Input channel req_: req_ch is the next byte, req_end_of_input ends the source
// (a zero byte does the same). A beat is taken when req_valid and req_ready are high.
// Result channel rsp_: one beat per token, error or end marker; rsp_is_last marks
// the last beat caused by one input beat; rsp_input_done marks the end marker.
// Literals, pairs and lone symbols are queued with their last byte; identifiers,
// numbers and pending symbols once the byte after them is taken. Throughput: one
// byte per cycle while req_ready is high, set by the classifier loop in the front.
// A four-entry queue separates classifier and output; req_ready drops only
// when it is full, so output stalls back up to the input once four entries wait.
// Reset: position 1:1, no pending token, error cleared, queue empty.
// After the end marker all further bytes are taken and dropped until reset.
module c_source_tokenizer
   import cst_pkg::*;
#(
   parameter int MAX_IDENT_LEN  = 256,
   parameter int MAX_STRING_LEN = 2048,
   parameter int POSITION_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_start_column,
   output logic [11:0] rsp_token_length,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_input_done,
   output logic        rsp_is_last
);

   logic q_push, q_full;
   entry_type q_entry;
   result_type res;

   cst_front #(
      .MAX_IDENT_LEN(MAX_IDENT_LEN),
      .MAX_STRING_LEN(MAX_STRING_LEN),
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_ch(req_ch), .in_eoi(req_end_of_input),
      .q_push(q_push), .q_entry(q_entry), .q_full(q_full)
   );

   cst_back u_back (
      .clock(clock), .reset(reset),
      .q_push(q_push), .q_entry(q_entry), .q_full(q_full),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_res(res)
   );

   assign rsp_token_kind   = res.kind;
   assign rsp_token_line   = res.line;
   assign rsp_start_column = res.column;
   assign rsp_token_length = res.length;
   assign rsp_error_code   = res.error;
   assign rsp_input_done   = res.done;
   assign rsp_is_last      = res.last;

endmodule

[rtl/cst_front.sv]
`timescale 1ns / 1ps
module cst_front
   import cst_pkg::*;
#(
   parameter int MAX_IDENT_LEN  = 256,
   parameter int MAX_STRING_LEN = 2048,
   parameter int POSITION_BITS  = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [7:0]      in_ch,
   input  logic            in_eoi,
   output logic            q_push,
   output entry_type       q_entry,
   input  logic            q_full
);

   localparam logic [POSITION_BITS-1:0] PMAX = {POSITION_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0] IDENT_MAX = LEN_BITS'(MAX_IDENT_LEN);
   localparam logic [LEN_BITS:0] STR_MAX = (LEN_BITS+1)'(MAX_STRING_LEN);

   mode_type mode_ff, mode_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in;
   logic [POSITION_BITS-1:0] tline_ff, tline_in, tcol_ff, tcol_in;
   logic [LEN_BITS:0] len_ff, len_in;
   logic [2:0] nf_ff, nf_in;
   logic [7:0] sym_ff, sym_in;
   logic esc_ff, esc_in;
   logic [3:0] err_ff, err_in;
   logic done_ff, done_in;

   logic [7:0] c;
   logic eoi, take;
   logic       n;
   result_type r [2];

   assign in_ready = !q_full;
   assign take = in_valid && in_ready;
   assign c = in_ch;
   assign eoi = in_eoi || (in_ch == 8'd0);

   function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
      if (POSITION_BITS > 16 && v > POSITION_BITS'(16'hffff)) sat16 = 16'hffff;
      else sat16 = 16'(v);
   endfunction

   function automatic logic [11:0] satl(input logic [LEN_BITS:0] v);
      satl = v[LEN_BITS] ? 12'hfff : v[LEN_BITS-1:0];
   endfunction

   always_comb begin
      logic alpha, digit, hexl, ws, restart, xx;
      logic [POSITION_BITS-1:0] pl, pc;
      logic [5:0] k;
      mode_in = mode_ff; line_in = line_ff; col_in = col_ff;
      tline_in = tline_ff; tcol_in = tcol_ff; len_in = len_ff;
      nf_in = nf_ff; sym_in = sym_ff; esc_in = esc_ff; err_in = err_ff;
      done_in = done_ff;
      n = 1'b0;
      r[0] = '0; r[1] = '0;
      restart = 1'b0;
      alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
      digit = c >= 8'h30 && c <= 8'h39;
      hexl = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
      ws = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
      xx = c == 8'h78 || c == 8'h58;
      pl = line_ff; pc = col_ff;
      k = pair_kind(sym_ff, c);
      q_push = 1'b0;
      if (take && !done_ff) begin
         if (eoi) begin
            if (err_ff == ERR_NONE) begin
               case (mode_ff)
                  MODE_IDENT: begin
                     r[0] = '{KIND_IDENT, sat16(tline_ff), sat16(tcol_ff), satl(len_ff),
                              ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                  end
                  MODE_NUM: begin
                     r[0] = '{nf_ff[0] ? KIND_FLOAT : KIND_INT, sat16(tline_ff),
                              sat16(tcol_ff), satl(len_ff), ERR_NONE, 1'b0, 1'b0};
                     n = 1'b1;
                  end
                  MODE_CHAR: begin
                     r[0] = '{KIND_IDENT, sat16(tline_ff), sat16(tcol_ff), satl(len_ff),
                              ERR_CHAR, 1'b0, 1'b0}; n = 1'b1;
                     err_in = ERR_CHAR;
                  end
                  MODE_STR: begin
                     r[0] = '{KIND_STRING, sat16(tline_ff), sat16(tcol_ff), satl(len_ff),
                              ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                  end
                  MODE_SYM: begin
                     r[0] = '{single_kind(sym_ff), sat16(tline_ff), sat16(tcol_ff), 12'd1,
                              ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                  end
                  default: ;
               endcase
            end
            mode_in = MODE_IDLE;
            r[n] = '{KIND_IDENT, sat16(line_ff), sat16(col_ff), 12'd0, err_in, 1'b1, 1'b1};
            done_in = 1'b1;
            q_push = 1'b1;
         end else if (err_ff == ERR_NONE) begin
            if (c == 8'h0a) begin
               col_in = POSITION_BITS'(1);
               if (line_ff < PMAX) line_in = line_ff + 1'b1;
            end else if (col_ff < PMAX) begin
               col_in = col_ff + 1'b1;
            end
            case (mode_ff)
               MODE_IDLE: restart = 1'b1;
               MODE_IDENT: begin
                  if (alpha || digit) begin
                     if (len_ff[LEN_BITS-1:0] >= IDENT_MAX && MAX_IDENT_LEN < 4096
                         || len_ff[LEN_BITS]) err_in = ERR_IDENT_LONG;
                     else len_in = len_ff + 1'b1;
                  end else begin
                     r[0] = '{KIND_IDENT, sat16(tline_ff), sat16(tcol_ff), satl(len_ff),
                              ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                     mode_in = MODE_IDLE; restart = 1'b1;
                  end
               end
               MODE_NUM: begin
                  if (len_ff >= (LEN_BITS+1)'(MAX_IDENT_LEN)) err_in = ERR_NUM_LONG;
                  else if (!(digit || hexl || c == 8'h2e || xx)) begin
                     r[0] = '{nf_ff[0] ? KIND_FLOAT : KIND_INT, sat16(tline_ff),
                              sat16(tcol_ff), satl(len_ff), ERR_NONE, 1'b0, 1'b0};
                     n = 1'b1; mode_in = MODE_IDLE; restart = 1'b1;
                  end else begin
                     len_in = len_ff + 1'b1;
                     if (c == 8'h2e) begin
                        if (nf_ff[0]) err_in = ERR_TWO_POINT;
                        else nf_in[0] = 1'b1;
                     end else if (xx) begin
                        if (nf_ff[0]) err_in = ERR_X_POINT;
                        else if (len_ff != 13'd1 || !nf_ff[2]) err_in = ERR_X_PLACE;
                        else nf_in[1] = 1'b1;
                     end else if (hexl) begin
                        if (nf_ff[0]) begin
                           if (c != 8'h66 && c != 8'h46) err_in = ERR_FLOAT_LET;
                        end else if (!nf_ff[1]) err_in = ERR_HEX_LET;
                     end
                  end
               end
               MODE_CHAR: begin
                  len_in = len_ff + 1'b1;
                  if (len_ff == 13'd1 && c == 8'h5c) esc_in = 1'b1;
                  if (c == 8'h27) begin
                     if (len_ff == 13'd3 && !esc_in) err_in = ERR_CHAR;
                     else begin
                        r[0] = '{KIND_CHAR, sat16(tline_ff), sat16(tcol_ff), satl(len_in),
                                 ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                        mode_in = MODE_IDLE;
                     end
                  end else if (len_ff >= 13'd3) err_in = ERR_CHAR;
               end
               MODE_STR: begin
                  if (esc_ff) begin
                     len_in = len_ff + 1'b1; esc_in = 1'b0;
                  end else if (len_ff >= STR_MAX) err_in = ERR_STR_LONG;
                  else begin
                     len_in = len_ff + 1'b1;
                     if (c == 8'h22) begin
                        r[0] = '{KIND_STRING, sat16(tline_ff), sat16(tcol_ff), satl(len_in),
                                 ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                        mode_in = MODE_IDLE;
                     end else if (c == 8'h5c) esc_in = 1'b1;
                  end
               end
               MODE_SYM: begin
                  if (sym_ff == 8'h2f && c == 8'h2f) mode_in = MODE_COMMENT;
                  else if (k != 6'd0) begin
                     r[0] = '{k, sat16(tline_ff), sat16(tcol_ff), 12'd2, ERR_NONE,
                              1'b0, 1'b0}; n = 1'b1;
                     mode_in = MODE_IDLE;
                  end else begin
                     r[0] = '{single_kind(sym_ff), sat16(tline_ff), sat16(tcol_ff), 12'd1,
                              ERR_NONE, 1'b0, 1'b0}; n = 1'b1;
                     mode_in = MODE_IDLE; restart = 1'b1;
                  end
               end
               MODE_COMMENT: if (c == 8'h0a) mode_in = MODE_IDLE;
               default: begin
                  mode_in = MODE_IDLE; restart = 1'b1;
               end
            endcase
            if (err_in != ERR_NONE) begin
               r[0] = '{KIND_IDENT, sat16(tline_ff), sat16(tcol_ff), satl(len_in),
                        err_in, 1'b0, 1'b0}; n = 1'b1;
               mode_in = MODE_IDLE;
            end else if (restart && !ws) begin
               tline_in = pl; tcol_in = pc; len_in = (LEN_BITS+1)'(1);
               nf_in = 3'b000; esc_in = 1'b0;
               if (alpha) mode_in = MODE_IDENT;
               else if (digit) begin
                  mode_in = MODE_NUM;
                  if (c == 8'h30) nf_in = 3'b100;
               end else if (c == 8'h27) mode_in = MODE_CHAR;
               else if (c == 8'h22) mode_in = MODE_STR;
               else if (combinable(c)) begin
                  mode_in = MODE_SYM; sym_in = c;
               end else if (single_kind(c) != 6'd0) begin
                  r[n] = '{single_kind(c), sat16(pl), sat16(pc), 12'd1, ERR_NONE,
                           1'b0, 1'b0};
                  n = n + 1'b1;
               end else begin
                  err_in = ERR_BAD_BYTE;
                  r[n] = '{KIND_IDENT, sat16(pl), sat16(pc), 12'd1, ERR_BAD_BYTE,
                           1'b0, 1'b0};
                  n = n + 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            q_push = 1'b0;
            if (r[0].length != 12'd0 || r[1].length != 12'd0) q_push = 1'b1;
         end
      end
   end

   always_comb begin
      q_entry = '0;
      if (done_in && !done_ff) begin
         q_entry.cnt = n;
         q_entry.r0 = r[0];
         q_entry.r1 = r[1];
         q_entry.r0.last = !n;
         q_entry.r1.last = 1'b1;
      end else if (r[1].length != 12'd0) begin
         q_entry.cnt = 1'b1;
         q_entry.r0 = r[0];
         q_entry.r1 = r[1];
         q_entry.r1.last = 1'b1;
      end else begin
         q_entry.cnt = 1'b0;
         q_entry.r0 = r[0];
         q_entry.r0.last = 1'b1;
         q_entry.r1 = r[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= POSITION_BITS'(1);
         col_ff <= POSITION_BITS'(1);
         tline_ff <= '0; tcol_ff <= '0; len_ff <= '0;
         nf_ff <= '0; sym_ff <= '0; esc_ff <= 1'b0; err_ff <= ERR_NONE;
         done_ff <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in;
         tline_ff <= tline_in; tcol_ff <= tcol_in; len_ff <= len_in;
         nf_ff <= nf_in; sym_ff <= sym_in; esc_ff <= esc_in; err_ff <= err_in;
         done_ff <= done_in;
      end
   end

endmodule

[rtl/cst_back.sv]
`timescale 1ns / 1ps
module cst_back
   import cst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_push,
   input  entry_type   q_entry,
   output logic        q_full,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_res
);

   entry_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic sub_ff;
   logic pop;

   assign q_full = cnt_ff[2];
   assign out_valid = cnt_ff != 3'd0;
   assign out_res = sub_ff ? mem_ff[rp_ff].r1 : mem_ff[rp_ff].r0;
   assign pop = out_valid && out_ready && (sub_ff || !mem_ff[rp_ff].cnt);

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wp_ff] <= q_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; sub_ff <= 1'b0;
      end else begin
         if (q_push) wp_ff <= wp_ff + 1'b1;
         if (pop) begin
            rp_ff <= rp_ff + 1'b1; sub_ff <= 1'b0;
         end else if (out_valid && out_ready) sub_ff <= 1'b1;
         cnt_ff <= cnt_ff + {2'b0, q_push} - {2'b0, pop};
      end
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench
   import cst_pkg::*;
();

   localparam int IDENT_MAX     = 256;
   localparam int STRING_MAX    = 2048;
   localparam int POS_MAX       = 65535;
   localparam int OP_KIND_FIRST = 5;
   localparam int STALL_LIMIT   = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'd32;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_token_line;
   logic [15:0] rsp_start_column;
   logic [11:0] rsp_token_length;
   logic [3:0]  rsp_error_code;
   logic        rsp_input_done;
   logic        rsp_is_last;

   c_source_tokenizer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ch(req_ch), .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_token_kind(rsp_token_kind), .rsp_token_line(rsp_token_line),
      .rsp_start_column(rsp_start_column), .rsp_token_length(rsp_token_length),
      .rsp_error_code(rsp_error_code), .rsp_input_done(rsp_input_done),
      .rsp_is_last(rsp_is_last)
   );

   always #10 clock = ~clock;

   // operator spellings, kind is OP_KIND_FIRST plus the index
   string op_text[36] = '{"+", "-", "*", "/", "%", "(", ")", "{", "}", "[", "]", ">",
                          "<", "=", "!", "|", "&", "~", ".", ";", "++", "+=", "--",
                          "-=", "->", "/=", "*=", "%=", ">=", "<=", "==", "!=", "||",
                          "|=", "&&", "&="};

   result_type  tokens_due[$];
   result_type  fresh[$];
   logic [7:0]  text_q[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          hold_cnt = 0;
   bit          calm = 0;

   // tokenizer state
   mode_type    mode = MODE_IDLE;
   int          line_no = 1, col_no = 1, tok_line = 0, tok_col = 0, tok_len = 0;
   logic [2:0]  num_flags = 3'd0;
   logic [7:0]  pend_op = 8'd0;
   bit          escaped = 0;
   logic [3:0]  sticky = ERR_NONE;
   bit          finished = 0;

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_hex_letter(logic [7:0] c);
      return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [5:0] op_kind(string s);
      foreach (op_text[i])
         if (op_text[i] == s) return 6'(OP_KIND_FIRST + i);
      if (s == "~=") return op_kind("!=");
      return KIND_IDENT;
   endfunction

   function automatic bit opens_pair(logic [7:0] c);
      foreach (op_text[i])
         if (op_text[i].len() == 2 && op_text[i][0] == c) return 1;
      return c == "~";
   endfunction

   function automatic logic [5:0] op_pair(logic [7:0] a, logic [7:0] b);
      string s;
      s = "  ";
      s[0] = a;
      s[1] = b;
      return op_kind(s);
   endfunction

   function automatic logic [5:0] op_single(logic [7:0] a);
      string s;
      s = " ";
      s[0] = a;
      return op_kind(s);
   endfunction

   function automatic void post(logic [5:0] kind, int ln, int col, int len,
                                logic [3:0] err, bit dn);
      result_type r;
      r.kind   = kind;
      r.line   = 16'(ln > POS_MAX ? POS_MAX : ln);
      r.column = 16'(col > POS_MAX ? POS_MAX : col);
      r.length = 12'(len > 4095 ? 4095 : len);
      r.error  = err;
      r.done   = dn;
      r.last   = 1'b0;
      fresh.insert(fresh.size(), r);
   endfunction

   function automatic void fail_token(logic [3:0] code);
      sticky = code;
      post(KIND_IDENT, tok_line, tok_col, tok_len, code, 0);
      mode = MODE_IDLE;
   endfunction

   function automatic logic [5:0] number_kind();
      return num_flags[0] ? KIND_FLOAT : KIND_INT;
   endfunction

   function automatic void open_token(logic [7:0] c, int pl, int pc);
      if (c == " " || (c >= 9 && c <= 13)) return;
      tok_line = pl;
      tok_col = pc;
      tok_len = 1;
      num_flags = 3'd0;
      escaped = 0;
      if (is_alpha(c)) mode = MODE_IDENT;
      else if (is_digit(c)) begin
         mode = MODE_NUM;
         if (c == "0") num_flags = 3'b100;
      end else if (c == "'") mode = MODE_CHAR;
      else if (c == "\"") mode = MODE_STR;
      else if (opens_pair(c)) begin
         mode = MODE_SYM;
         pend_op = c;
      end else if (op_single(c) != KIND_IDENT) post(op_single(c), pl, pc, 1, ERR_NONE, 0);
      else fail_token(ERR_BAD_BYTE);
   endfunction

   // returns 1 when the byte ends the token and must open a new one
   function automatic bit extend_token(logic [7:0] c);
      int old;
      logic [5:0] k;
      case (mode)
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               if (tok_len >= IDENT_MAX) fail_token(ERR_IDENT_LONG);
               else tok_len++;
               return 0;
            end
            post(KIND_IDENT, tok_line, tok_col, tok_len, ERR_NONE, 0);
            mode = MODE_IDLE;
            return 1;
         end
         MODE_NUM: begin
            old = tok_len;
            if (tok_len >= IDENT_MAX) begin
               fail_token(ERR_NUM_LONG);
               return 0;
            end
            if (!(is_digit(c) || is_hex_letter(c) || c == "." || c == "x" || c == "X")) begin
               post(number_kind(), tok_line, tok_col, tok_len, ERR_NONE, 0);
               mode = MODE_IDLE;
               return 1;
            end
            tok_len++;
            if (c == ".") begin
               if (num_flags[0]) begin
                  fail_token(ERR_TWO_POINT);
                  return 0;
               end
               num_flags[0] = 1'b1;
            end
            if (c == "x" || c == "X") begin
               if (num_flags[0]) begin
                  fail_token(ERR_X_POINT);
                  return 0;
               end
               if (old != 1 || !num_flags[2]) begin
                  fail_token(ERR_X_PLACE);
                  return 0;
               end
               num_flags[1] = 1'b1;
            end
            if (is_hex_letter(c)) begin
               if (num_flags[0]) begin
                  if (c != "f" && c != "F") fail_token(ERR_FLOAT_LET);
               end else if (!num_flags[1]) fail_token(ERR_HEX_LET);
            end
            return 0;
         end
         MODE_CHAR: begin
            old = tok_len;
            tok_len++;
            if (old == 1 && c == "\\") escaped = 1;
            if (c == "'") begin
               if (old == 3 && !escaped) begin
                  fail_token(ERR_CHAR);
                  return 0;
               end
               post(KIND_CHAR, tok_line, tok_col, tok_len, ERR_NONE, 0);
               mode = MODE_IDLE;
            end else if (old >= 3) fail_token(ERR_CHAR);
            return 0;
         end
         MODE_STR: begin
            if (escaped) begin
               tok_len++;
               escaped = 0;
               return 0;
            end
            if (tok_len >= STRING_MAX) begin
               fail_token(ERR_STR_LONG);
               return 0;
            end
            tok_len++;
            if (c == "\"") begin
               post(KIND_STRING, tok_line, tok_col, tok_len, ERR_NONE, 0);
               mode = MODE_IDLE;
            end else if (c == "\\") escaped = 1;
            return 0;
         end
         MODE_SYM: begin
            if (pend_op == "/" && c == "/") begin
               mode = MODE_COMMENT;
               return 0;
            end
            k = op_pair(pend_op, c);
            mode = MODE_IDLE;
            if (k != KIND_IDENT) begin
               post(k, tok_line, tok_col, 2, ERR_NONE, 0);
               return 0;
            end
            post(op_single(pend_op), tok_line, tok_col, 1, ERR_NONE, 0);
            return 1;
         end
         MODE_COMMENT: begin
            if (c == 8'h0a) mode = MODE_IDLE;
            return 0;
         end
         default: begin
            mode = MODE_IDLE;
            return 1;
         end
      endcase
   endfunction

   function automatic void flush_token();
      case (mode)
         MODE_IDENT: post(KIND_IDENT, tok_line, tok_col, tok_len, ERR_NONE, 0);
         MODE_NUM:   post(number_kind(), tok_line, tok_col, tok_len, ERR_NONE, 0);
         MODE_CHAR:  fail_token(ERR_CHAR);
         MODE_STR:   post(KIND_STRING, tok_line, tok_col, tok_len, ERR_NONE, 0);
         MODE_SYM:   post(op_single(pend_op), tok_line, tok_col, 1, ERR_NONE, 0);
         default: ;
      endcase
      mode = MODE_IDLE;
   endfunction

   function automatic void lex_byte(logic [7:0] c, logic eoi);
      int pl, pc;
      fresh.delete();
      if (finished) return;
      if (eoi || c == 8'd0) begin
         if (sticky == ERR_NONE) flush_token();
         post(KIND_IDENT, line_no, col_no, 0, sticky, 1);
         finished = 1;
      end else if (sticky == ERR_NONE) begin
         pl = line_no;
         pc = col_no;
         if (c == 8'h0a) begin
            col_no = 1;
            if (line_no < POS_MAX) line_no++;
         end else if (col_no < POS_MAX) col_no++;
         if (mode == MODE_IDLE || extend_token(c))
            if (sticky == ERR_NONE) open_token(c, pl, pc);
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) tokens_due.insert(tokens_due.size(), fresh[i]);
   endfunction

   task automatic send_byte(logic [7:0] c, logic eoi);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      lex_byte(c, eoi);
   endtask

   task automatic send_text();
      while (text_q.size() > 0) send_byte(text_q.pop_front(), 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() > 0) @(posedge clock);
   endtask

   function automatic void put_byte(logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic logic [7:0] any_byte_but(logic [7:0] a, logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
      return c;
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25) : "A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_hex();
      case ($urandom_range(0, 2))
         0: return rand_digit();
         1: return 8'("a" + $urandom_range(0, 5));
         default: return 8'("A" + $urandom_range(0, 5));
      endcase
   endfunction

   function automatic void add_ident(int n);
      put_byte(rand_letter());
      for (int i = 1; i < n; i++)
         put_byte($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
   endfunction

   function automatic void add_number();
      int n;
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 3))
         0: begin
            put_byte(8'("1" + $urandom_range(0, 8)));
            repeat (n) put_byte(rand_digit());
         end
         1: add_text("0");
         2: begin
            add_text($urandom_range(0, 1) ? "0x" : "0X");
            repeat (n + 1) put_byte(rand_hex());
         end
         default: begin
            repeat (n + 1) put_byte(rand_digit());
            add_text(".");
            repeat ($urandom_range(0, 4)) put_byte(rand_digit());
            if ($urandom_range(0, 2) == 0) add_text($urandom_range(0, 1) ? "f" : "F");
         end
      endcase
   endfunction

   function automatic void add_char_literal();
      add_text("'");
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            add_text("\\");
            put_byte(any_byte_but("'", 8'd0));
         end
         default: put_byte(any_byte_but("'", "\\"));
      endcase
      add_text("'");
   endfunction

   function automatic void add_string(int n);
      add_text("\"");
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 6) == 0 && i < n - 1) begin
            add_text("\\");
            put_byte(any_byte_but(8'd0, 8'd0));
            i++;
         end else put_byte(any_byte_but("\"", "\\"));
      end
      add_text("\"");
   endfunction

   function automatic void add_gap();
      logic [7:0] ws[6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
      repeat ($urandom_range(1, 2)) put_byte(ws[$urandom_range(0, 5)]);
   endfunction

   function automatic void add_random_token();
      case ($urandom_range(0, 9))
         0, 1: begin
            add_ident($urandom_range(1, 12));
            if ($urandom_range(0, 4) == 0) add_text(";");
         end
         2, 3: add_number();
         4: add_char_literal();
         5: add_string($urandom_range(0, 12));
         6, 7, 8: begin
            add_text($urandom_range(0, 15) == 0 ? "~=" : op_text[$urandom_range(0, 35)]);
            if ($urandom_range(0, 4) == 0) add_ident($urandom_range(1, 4));
         end
         default: begin
            add_text("//");
            repeat ($urandom_range(0, 10)) put_byte(any_byte_but(8'h0a, 8'h0a));
            put_byte(8'h0a);
         end
      endcase
      add_gap();
   endfunction

   task automatic test_directed_tokens();
      add_text("x9 0x1F 1.f '\\n' \"\\\"\" ~= //\n");
      send_text();
   endtask

   task automatic test_length_limits();
      add_ident(IDENT_MAX);
      add_text(" ");
      repeat (IDENT_MAX - 1) put_byte(rand_digit());
      add_text(" \n");
      send_text();
   endtask

   task automatic test_random_source();
      int sent;
      sent = 0;
      while (sent < 1100) begin
         add_random_token();
         sent += text_q.size();
         send_text();
      end
   endtask

   task automatic test_end_of_source();
      calm = 1;
      case ($urandom_range(0, 16))
         0: add_ident(3);
         1: add_text("+");
         2: add_text("\"ab\\");
         3: add_text("'\\");
         4: add_text("// tail");
         5: put_byte(8'($urandom_range(128, 255)));
         6: add_text("#");
         7: add_ident(IDENT_MAX + 1);
         8: repeat (IDENT_MAX + 1) put_byte(rand_digit());
         9: add_text("1.2.");
         10: add_text("1.x");
         11: add_text("12x");
         12: add_text("1.e");
         13: add_text("7a");
         14: add_text("'abc'");
         15: begin
            add_text("\"");
            repeat (STRING_MAX - 1) put_byte(any_byte_but("\"", "\\"));
            add_text("z");
         end
         default: add_number();
      endcase
      repeat ($urandom_range(0, 3)) put_byte(any_byte_but(8'd0, 8'd0));
      send_text();
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
      else send_byte(8'd0, 1'b0);
   endtask

   task automatic test_after_done();
      repeat (16) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (!reset && !calm && $urandom_range(0, 9) == 0) begin
         hold_cnt <= $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   task automatic compare(string field, int want, int got);
      if (want != got) begin
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tokens_due.size() == 0) begin
            $display("%0t unexpected beat kind %0d", $time, rsp_token_kind);
            mismatches++;
         end else begin
            e = tokens_due.pop_front();
            compare("token_kind", e.kind, rsp_token_kind);
            compare("token_line", e.line, rsp_token_line);
            compare("start_column", e.column, rsp_start_column);
            compare("token_length", e.length, rsp_token_length);
            compare("error_code", e.error, rsp_error_code);
            compare("input_done", e.done, rsp_input_done);
            compare("is_last", e.last, rsp_is_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t stalled, %0d beats outstanding", $time, tokens_due.size());
         $display("Some tests failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tokens();
      test_length_limits();
      wait_drained();
      test_random_source();
      test_end_of_source();
      test_after_done();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
